### sv/rap_pkg.sv
// Shared types and constants for the rectangle atlas placer.
// Holds the field width, state, command, status and config codes and rectangle layouts.
// No dependencies.
package rap_pkg;

    localparam int C_W = 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_LOAD,
        S_BOUND,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [C_W-1:0] x;
        logic [C_W-1:0] y;
        logic [C_W-1:0] w;
        logic [C_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic [C_W:0]   x;
        logic [C_W:0]   y;
        logic [C_W-1:0] w;
        logic [C_W-1:0] h;
    } t_cand;

    localparam logic       CMD_PLACE = 1'b0;
    localparam logic       CMD_ADD   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_AREA_W  = 2'd0;
    localparam logic [1:0] CFG_AREA_H  = 2'd1;
    localparam logic [1:0] CFG_SPACING = 2'd2;

endpackage

### sv/rap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the placed-rectangle table. No dependencies.
module rap_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rap_geom.sv
// Shared overlap unit: tests one stored rectangle, other than the source one, against the candidate spot.
// Depends on rap_pkg.
module rap_geom
    import rap_pkg::*;
(
    input  t_rect i_entry,
    input  t_cand i_cand,
    input  t_rect i_src,
    output logic  o_conflict
);
    logic ovl_x;
    logic ovl_y;
    logic same;

    assign ovl_x = ((C_W+2)'(i_entry.x) < ((C_W+2)'(i_cand.x) + (C_W+2)'(i_cand.w))) &&
                   ((C_W+2)'(i_cand.x) < ((C_W+2)'(i_entry.x) + (C_W+2)'(i_entry.w)));
    assign ovl_y = ((C_W+2)'(i_entry.y) < ((C_W+2)'(i_cand.y) + (C_W+2)'(i_cand.h))) &&
                   ((C_W+2)'(i_cand.y) < ((C_W+2)'(i_entry.y) + (C_W+2)'(i_entry.h)));
    assign same  = (i_entry == i_src);

    assign o_conflict = ovl_x && ovl_y && !same;

endmodule

### sv/rect_atlas_placer.sv
// Rectangle atlas placer top level: request channels, sequencer and table.
// Depends on rap_pkg, rap_ram and rap_geom.
//
// Usage:
//   A request enters on the s_axis channel: tuser selects place or add, tdata carries
//   position and size. Exactly one result leaves on the m_axis channel: tuser holds
//   the status, tdata the position and the (padded) size.
//   Area width, area height and spacing are written through i_cfg_*; the user must
//   write them only while idle, and the block does not enforce it. An add, a full
//   table or an empty table shows its result in the next cycle. A place search reads
//   stored rectangle k, then for each of its two spots runs one bound check and, if
//   that passes, a scan of the N stored entries that stops at the first overlap,
//   through the single table read port and the shared overlap unit, one entry per
//   cycle. A full table of 64 answers without a search.
//   s_axis_tready is high only while idle; one request is in flight at a time.
//   The result is held in registers until m_axis_tready takes it.
//   Synchronous reset empties the table (count zero) and restores the register
//   defaults: area 1024 by 1024, spacing off.
module rect_atlas_placer
    import rap_pkg::*;
#(
    parameter int MAX_RECTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // pos_x, pos_y, size_w, size_h, zero pad
    input  logic                 s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,  // out_x, out_y, out_w, out_h, zero pad
    output logic [1:0]           m_axis_tuser,  // status
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [C_W-1:0]       i_cfg_data
);
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RECTS);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_phase, n_phase;
    logic [CNT_W-1:0] r_ri, n_ri;
    logic             r_pend, n_pend;
    t_rect            r_src, n_src;
    logic [C_W:0]     r_cx, n_cx;
    logic [C_W:0]     r_cy, n_cy;
    logic [1:0]       r_status, n_status;
    logic [C_W-1:0]   r_ox, n_ox;
    logic [C_W-1:0]   r_oy, n_oy;
    logic [C_W-1:0]   r_ow, n_ow;
    logic [C_W-1:0]   r_oh, n_oh;
    logic [C_W-1:0]   r_area_w;
    logic [C_W-1:0]   r_area_h;
    logic             r_spacing;

    logic [C_W-1:0]   in_x, in_y, in_w, in_h;
    logic [C_W-1:0]   pad_w, pad_h;
    logic             full;
    logic             fits;
    logic             conflict;
    logic             adv;
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    t_rect            ram_wdata;
    t_rect            ram_rdata;
    t_cand            cand;

    assign in_x = s_axis_tdata[C_W-1:0];
    assign in_y = s_axis_tdata[2*C_W-1:C_W];
    assign in_w = s_axis_tdata[3*C_W-1:2*C_W];
    assign in_h = s_axis_tdata[4*C_W-1:3*C_W];

    assign pad_w = (r_spacing && ((C_W+1)'(in_w) + 1'b1 < (C_W+1)'(r_area_w))) ?
                   in_w + 1'b1 : in_w;
    assign pad_h = (r_spacing && ((C_W+1)'(in_h) + 1'b1 < (C_W+1)'(r_area_h))) ?
                   in_h + 1'b1 : in_h;

    assign full = (r_count == FULL_CNT);
    assign fits = ((C_W+2)'(r_cx) + (C_W+2)'(r_ow) <= (C_W+2)'(r_area_w)) &&
                  ((C_W+2)'(r_cy) + (C_W+2)'(r_oh) <= (C_W+2)'(r_area_h));

    assign cand = '{x: r_cx, y: r_cy, w: r_ow, h: r_oh};

    rap_ram #(
        .WIDTH ($bits(t_rect)),
        .DEPTH (MAX_RECTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rap_geom u_geom (
        .i_entry    (ram_rdata),
        .i_cand     (cand),
        .i_src      (r_src),
        .o_conflict (conflict)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_phase   = r_phase;
        n_ri      = r_ri;
        n_pend    = r_pend;
        n_src     = r_src;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_status  = r_status;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_ow      = r_ow;
        n_oh      = r_oh;
        ram_we    = 1'b0;
        ram_wdata = '{x: r_cx[C_W-1:0], y: r_cy[C_W-1:0], w: r_ow, h: r_oh};
        ram_raddr = r_k;
        adv       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DONE;
                    n_ox    = '0;
                    n_oy    = '0;
                    if (s_axis_tuser == CMD_ADD) begin
                        n_ow = in_w;
                        n_oh = in_h;
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = '{x: in_x, y: in_y, w: in_w, h: in_h};
                            n_count   = r_count + 1'b1;
                            n_status  = ST_OK;
                            n_ox      = in_x;
                            n_oy      = in_y;
                        end
                    end else begin
                        n_ow = pad_w;
                        n_oh = pad_h;
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_wdata = '{x: '0, y: '0, w: pad_w, h: pad_h};
                            n_count   = r_count + 1'b1;
                            n_status  = ST_OK;
                        end else begin
                            n_k     = '0;
                            n_state = S_SRC;
                        end
                    end
                end
            end
            S_SRC: begin
                ram_raddr = r_k;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                n_src   = ram_rdata;
                n_cx    = (C_W+1)'(ram_rdata.x) + (C_W+1)'(ram_rdata.w);
                n_cy    = (C_W+1)'(ram_rdata.y);
                n_phase = 1'b0;
                n_state = S_BOUND;
            end
            S_BOUND: begin
                if (fits) begin
                    n_ri    = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    adv = 1'b1;
                end
            end
            S_SCAN: begin
                ram_raddr = r_ri[IDX_W-1:0];
                if (r_pend && conflict) begin
                    adv = 1'b1;
                end else if (!r_pend && r_ri == r_count) begin
                    ram_we   = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_status = ST_OK;
                    n_ox     = r_cx[C_W-1:0];
                    n_oy     = r_cy[C_W-1:0];
                    n_state  = S_DONE;
                end else begin
                    n_pend = (r_ri < r_count);
                    if (r_ri < r_count) begin
                        n_ri = r_ri + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance to the spot below, then to the next stored rectangle, or report no fit after the last one
        if (adv) begin
            if (!r_phase) begin
                n_cx    = (C_W+1)'(r_src.x);
                n_cy    = (C_W+1)'(r_src.y) + (C_W+1)'(r_src.h);
                n_phase = 1'b1;
                n_state = S_BOUND;
            end else if (CNT_W'({1'b0, r_k}) + 1'b1 == r_count) begin
                n_status = ST_NOFIT;
                n_ox     = '0;
                n_oy     = '0;
                n_state  = S_DONE;
            end else begin
                n_k     = r_k + 1'b1;
                n_state = S_SRC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_phase   <= 1'b0;
            r_ri      <= '0;
            r_pend    <= 1'b0;
            r_area_w  <= C_W'(1024);
            r_area_h  <= C_W'(1024);
            r_spacing <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_ri    <= n_ri;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AREA_W:  r_area_w  <= i_cfg_data;
                    CFG_AREA_H:  r_area_h  <= i_cfg_data;
                    CFG_SPACING: r_spacing <= i_cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_status <= n_status;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ow     <= n_ow;
        r_oh     <= n_oh;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {4'b0000, r_oh, r_ow, r_oy, r_ox};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("table count beyond capacity");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |-> r_count == $past(r_count) + 1'b1)
        else $error("table count moved by more than one");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !full)
        else $error("table write while full");

    a_store_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> m_axis_tvalid && m_axis_tuser == ST_OK)
        else $error("stored rectangle without a success result");

endmodule
